/* rtl/core/lru_pkg.sv */
package lru_pkg;

    localparam int COUNT_W = 16;
    localparam int CFG_W   = 5;
    localparam int LIM_W   = 8;

    localparam logic [CFG_W-1:0]   FRAME_COUNT_RESET = 5'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;

    typedef enum logic [0:0] {
        REG_FRAME_COUNT = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic start;
        logic hit;
        logic evict;
        logic fill;
    } t_cell_ctl;

endpackage

/* rtl/core/lru_page_replacement.sv */
// Fully associative LRU page-frame tracker built as a row of MAX_FRAMES recency cells,
// slot 0 least recent. Pulse start with a page (and start_req to begin a new sequence,
// which empties the frames and clears the counters); busy stays low, so a new reference
// can be issued every clock. Every reference gives exactly one result beat, marked by
// o_done in the cycle after the start cycle, holding hit, any evicted page and the
// saturating hit and miss counts; the result is valid for that single cycle only and
// cannot be stalled, so capture it when o_done is high. The rate of one reference per
// cycle is set by the compare-and-shift cell row, where every cell updates in the same
// cycle. frame_count (register 0) takes effect on the next reference, zero acting as one
// and values above MAX_FRAMES as MAX_FRAMES; write it only between references.
module lru_page_replacement #(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [PAGE_BITS-1:0]        i_page,
    input  logic                        i_start_req,
    output logic                        o_done,
    output logic                        o_hit,
    output logic                        o_evicted_valid,
    output logic [PAGE_BITS-1:0]        o_evicted_page,
    output logic [lru_pkg::COUNT_W-1:0] o_hit_count,
    output logic [lru_pkg::COUNT_W-1:0] o_miss_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int FU_W = $clog2(MAX_FRAMES + 1);

    logic [lru_pkg::CFG_W-1:0]   r_frame_count;
    logic [FU_W-1:0]             r_used;
    logic [FU_W-1:0]             n_used;
    logic [lru_pkg::COUNT_W-1:0] r_hits;
    logic [lru_pkg::COUNT_W-1:0] r_misses;
    logic [lru_pkg::COUNT_W-1:0] n_hits;
    logic [lru_pkg::COUNT_W-1:0] n_misses;
    logic                        r_done;
    logic                        r_hit;
    logic                        r_ev_valid;
    logic [PAGE_BITS-1:0]        r_ev_page;

    logic [MAX_FRAMES-1:0]       w_valid;
    logic [PAGE_BITS-1:0]        w_page [MAX_FRAMES];
    logic [MAX_FRAMES:0]         w_seen;
    logic [FU_W-1:0]             w_used;
    logic [lru_pkg::LIM_W-1:0]   w_lim;
    logic                        w_full;
    logic                        w_accept;
    logic                        w_hit;
    lru_pkg::t_cell_ctl          w_ctl;
    logic                        w_cfg_wr;

    assign busy     = 1'b0;
    assign pready   = 1'b1;
    assign w_accept = start & ~busy;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= lru_pkg::FRAME_COUNT_RESET;
        end else if (w_cfg_wr && (paddr[2] == lru_pkg::REG_FRAME_COUNT)) begin
            r_frame_count <= pwdata[lru_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == lru_pkg::REG_FRAME_COUNT) begin
            prdata = 32'(r_frame_count);
        end
    end

    // effective frame limit
    always_comb begin
        w_lim = lru_pkg::LIM_W'(r_frame_count);
        if (w_lim == '0) begin
            w_lim = lru_pkg::LIM_W'(1);
        end
        if (w_lim > lru_pkg::LIM_W'(MAX_FRAMES)) begin
            w_lim = lru_pkg::LIM_W'(MAX_FRAMES);
        end
    end

    assign w_used = i_start_req ? '0 : r_used;
    assign w_full = lru_pkg::LIM_W'(w_used) >= w_lim;
    assign w_hit  = w_seen[MAX_FRAMES];

    assign w_ctl.start = w_accept & i_start_req;
    assign w_ctl.hit   = w_accept & w_hit;
    assign w_ctl.evict = w_accept & ~w_hit & w_full;
    assign w_ctl.fill  = w_accept & ~w_hit & ~w_full;

    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        logic                 w_up_valid;
        logic [PAGE_BITS-1:0] w_up_page;
        logic                 w_dn_valid;

        if (g == MAX_FRAMES - 1) begin : g_top
            assign w_up_valid = 1'b0;
            assign w_up_page  = '0;
        end else begin : g_mid
            assign w_up_valid = w_valid[g+1];
            assign w_up_page  = w_page[g+1];
        end

        if (g == 0) begin : g_bot
            assign w_dn_valid = 1'b1;
        end else begin : g_above
            assign w_dn_valid = w_valid[g-1];
        end

        lru_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_page     (i_page),
            .i_up_valid (w_up_valid),
            .i_up_page  (w_up_page),
            .i_dn_valid (w_dn_valid),
            .i_seen     (w_seen[g]),
            .o_seen     (w_seen[g+1]),
            .o_valid    (w_valid[g]),
            .o_page     (w_page[g])
        );
    end

    always_comb begin
        n_used   = w_used;
        n_hits   = i_start_req ? '0 : r_hits;
        n_misses = i_start_req ? '0 : r_misses;
        if (w_hit) begin
            if (n_hits != lru_pkg::COUNT_MAX) begin
                n_hits = n_hits + 1'b1;
            end
        end else begin
            if (n_misses != lru_pkg::COUNT_MAX) begin
                n_misses = n_misses + 1'b1;
            end
            if (!w_full) begin
                n_used = w_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_used   <= n_used;
                r_hits   <= n_hits;
                r_misses <= n_misses;
            end
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit      <= w_hit;
            r_ev_valid <= ~w_hit & w_full;
            r_ev_page  <= (~w_hit & w_full) ? w_page[0] : '0;
        end
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_hit_count     = r_hits;
    assign o_miss_count    = r_misses;

endmodule

/* rtl/core/lru_cell.sv */
module lru_cell #(
    parameter int PAGE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lru_pkg::t_cell_ctl     i_ctl,
    input  logic [PAGE_BITS-1:0]   i_page,
    input  logic                   i_up_valid,
    input  logic [PAGE_BITS-1:0]   i_up_page,
    input  logic                   i_dn_valid,
    input  logic                   i_seen,
    output logic                   o_seen,
    output logic                   o_valid,
    output logic [PAGE_BITS-1:0]   o_page
);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic                 n_valid;
    logic [PAGE_BITS-1:0] n_page;
    logic                 w_match;
    logic                 w_shift;

    assign o_valid = r_valid & ~i_ctl.start;
    assign o_page  = r_page;
    assign w_match = o_valid && (r_page == i_page);
    assign o_seen  = i_seen | w_match;
    assign w_shift = (i_ctl.hit && o_seen) || i_ctl.evict;

    always_comb begin
        n_valid = o_valid;
        n_page  = r_page;
        if (w_shift && o_valid) begin
            n_page = i_up_valid ? i_up_page : i_page;
        end else if (i_ctl.fill && !o_valid && i_dn_valid) begin
            n_page  = i_page;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule
